@@ hdl/bpc_pkg.sv @@
// Shared types, widths and codes for the button press classifier.
`default_nettype none
package bpc_pkg;

    localparam int TimeW  = 32;
    localparam int ThrW   = 16;
    localparam int ClassW = 3;
    localparam int CountW = 16;
    localparam int BeepW  = 2;
    localparam int ClrW   = 9;
    localparam int IdxW   = 2;

    localparam int InDataW  = 40;
    localparam int OutDataW = 24;

    localparam logic [ClassW-1:0] CLASS_NONE      = 3'd0;
    localparam logic [ClassW-1:0] CLASS_SHORT     = 3'd1;
    localparam logic [ClassW-1:0] CLASS_LONG      = 3'd2;
    localparam logic [ClassW-1:0] CLASS_VERY_LONG = 3'd3;
    localparam logic [ClassW-1:0] CLASS_HELD      = 3'd4;

    localparam logic [BeepW-1:0] BEEP_NONE      = 2'd0;
    localparam logic [BeepW-1:0] BEEP_SHORT     = 2'd1;
    localparam logic [BeepW-1:0] BEEP_LONG      = 2'd2;
    localparam logic [BeepW-1:0] BEEP_FOUR_LONG = 2'd3;

    localparam logic [IdxW-1:0] REG_LONG_THR      = 2'd0;
    localparam logic [IdxW-1:0] REG_VERY_LONG_THR = 2'd1;
    localparam logic [IdxW-1:0] REG_REPEAT_IVL    = 2'd2;
    localparam logic [IdxW-1:0] REG_CLEAR_TICKS   = 2'd3;

    localparam logic [ThrW-1:0] LONG_THR_RST      = 16'd1000;
    localparam logic [ThrW-1:0] VERY_LONG_THR_RST = 16'd5000;
    localparam logic [ThrW-1:0] REPEAT_IVL_RST    = 16'd200;
    localparam logic [ClrW-1:0] CLEAR_TICKS_RST   = 9'd300;

    typedef struct packed {
        logic [ThrW-1:0] long_threshold_ms;
        logic [ThrW-1:0] very_long_threshold_ms;
        logic [ThrW-1:0] repeat_interval_ms;
        logic [ClrW-1:0] clear_after_ticks;
    } bpc_cfg_t;

    typedef struct packed {
        logic [ClassW-1:0] press_class;
        logic [CountW-1:0] repeat_count;
        logic [BeepW-1:0]  beep_code;
    } bpc_result_t;

endpackage
`default_nettype wire

@@ hdl/bpc_cfg.sv @@
// Configuration register bank for the button press classifier.
`default_nettype none
module bpc_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [bpc_pkg::IdxW-1:0]  cfg_index,
    input  wire logic [bpc_pkg::ThrW-1:0]  cfg_data,
    output bpc_pkg::bpc_cfg_t              cfg
);
    import bpc_pkg::*;

    bpc_cfg_t cfg_reg;
    bpc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LONG_THR:      cfg_next.long_threshold_ms      = cfg_data;
                REG_VERY_LONG_THR: cfg_next.very_long_threshold_ms = cfg_data;
                REG_REPEAT_IVL:    cfg_next.repeat_interval_ms     = cfg_data;
                REG_CLEAR_TICKS:   cfg_next.clear_after_ticks      = cfg_data[ClrW-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_threshold_ms      <= LONG_THR_RST;
            cfg_reg.very_long_threshold_ms <= VERY_LONG_THR_RST;
            cfg_reg.repeat_interval_ms     <= REPEAT_IVL_RST;
            cfg_reg.clear_after_ticks      <= CLEAR_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/bpc_core.sv @@
// Press tracking state and per-tick classification logic.
`default_nettype none
module bpc_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic                       button_level,
    input  wire logic [bpc_pkg::TimeW-1:0]  now_ms,
    input  wire bpc_pkg::bpc_cfg_t          cfg,
    output bpc_pkg::bpc_result_t            result
);
    import bpc_pkg::*;

    logic              last_level_reg,     last_level_next;
    logic [TimeW-1:0]  press_start_reg,    press_start_next;
    logic [TimeW-1:0]  repeat_mark_reg,    repeat_mark_next;
    logic [CountW-1:0] repeat_counter_reg, repeat_counter_next;
    logic [ClassW-1:0] class_reg,          class_next;
    logic [ClrW-1:0]   clear_counter_reg,  clear_counter_next;
    logic [BeepW-1:0]  beep;

    logic [TimeW-1:0]  held_ms;
    logic [TimeW-1:0]  since_mark_ms;
    logic              past_very_long;
    logic              past_long;
    logic              repeat_due;
    logic [ClassW-1:0] class_mid;
    logic [ClrW-1:0]   clear_mid;
    logic [ClrW-1:0]   clear_inc;

    assign held_ms        = now_ms - press_start_reg;
    assign since_mark_ms  = now_ms - repeat_mark_reg;
    assign past_very_long = held_ms > {{(TimeW-ThrW){1'b0}}, cfg.very_long_threshold_ms};
    assign past_long      = held_ms > {{(TimeW-ThrW){1'b0}}, cfg.long_threshold_ms};
    assign repeat_due     = since_mark_ms > {{(TimeW-ThrW){1'b0}}, cfg.repeat_interval_ms};

    always_comb
    begin
        press_start_next    = press_start_reg;
        repeat_mark_next    = repeat_mark_reg;
        repeat_counter_next = repeat_counter_reg;
        class_mid           = class_reg;
        clear_mid           = clear_counter_reg;
        beep                = BEEP_NONE;

        if (!button_level)
        begin
            if (last_level_reg)
            begin
                press_start_next    = now_ms;
                repeat_mark_next    = now_ms;
                repeat_counter_next = '0;
            end
            else if (!past_very_long && repeat_due)
            begin
                repeat_mark_next    = now_ms;
                class_mid           = CLASS_HELD;
                repeat_counter_next = repeat_counter_reg + 1'b1;
            end
        end
        else if (!last_level_reg)
        begin
            if (past_very_long)
            begin
                class_mid = CLASS_VERY_LONG;
                beep      = BEEP_FOUR_LONG;
            end
            else if (past_long)
            begin
                class_mid = CLASS_LONG;
                beep      = BEEP_LONG;
            end
            else
            begin
                class_mid = CLASS_SHORT;
                beep      = BEEP_SHORT;
            end
            clear_mid = '0;
        end

        last_level_next    = button_level;
        clear_inc          = clear_mid + 1'b1;
        class_next         = class_mid;
        clear_counter_next = clear_mid;
        if (class_mid == CLASS_LONG || class_mid == CLASS_SHORT)
        begin
            clear_counter_next = clear_inc;
            if (clear_inc >= cfg.clear_after_ticks || clear_inc == '0)
            begin
                class_next         = CLASS_NONE;
                clear_counter_next = '0;
            end
        end
    end

    assign result.press_class  = class_next;
    assign result.repeat_count = repeat_counter_next;
    assign result.beep_code    = beep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg     <= 1'b1;
            press_start_reg    <= '0;
            repeat_mark_reg    <= '0;
            repeat_counter_reg <= '0;
            class_reg          <= CLASS_NONE;
            clear_counter_reg  <= '0;
        end
        else if (step)
        begin
            last_level_reg     <= last_level_next;
            press_start_reg    <= press_start_next;
            repeat_mark_reg    <= repeat_mark_next;
            repeat_counter_reg <= repeat_counter_next;
            class_reg          <= class_next;
            clear_counter_reg  <= clear_counter_next;
        end
    end

`ifndef SYNTHESIS
    a_beep_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (step && beep != BEEP_NONE) |-> (!last_level_reg && button_level))
        else $error("beep outside a release tick");

    a_press_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !button_level && last_level_reg) |=> (repeat_counter_reg == '0))
        else $error("repeat count not cleared on press");

    a_held_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && class_next == CLASS_HELD && class_reg != CLASS_HELD)
        |-> (repeat_counter_next == repeat_counter_reg + 1'b1))
        else $error("held class entered without a repeat");
`endif

endmodule
`default_nettype wire

@@ hdl/button_press_classifier.sv @@
// Top level: button press classifier with stream channels and register port.
// Usage:
//   s_axis carries one poll tick per beat: button level (0 pressed) and a
//   wrapping millisecond timestamp. m_axis returns one result beat per input
//   beat: press class, repeat count and a one-tick beep code.
//   cfg writes one of four registers (long, very long, repeat interval, clear
//   ticks); write only while no beat is in flight. cfg_ready is always high.
// Path: an accepted beat is registered in the input register, classified
//   combinationally from there and registered into the result register that
//   drives m_axis; while m_axis is stalled it waits in the input register.
// Throughput: one beat per cycle while m_axis_tready stays high; set by the
//   single classify step between the input register and the result register.
// Reset: all press state clears, the button counts as released, class none,
//   registers return to 1000 / 5000 / 200 ms and 300 ticks.
// Stalls: with m_axis_tready low the result register holds; the input
//   register still takes one beat, then s_axis_tready drops until the
//   result is taken.
`default_nettype none
module button_press_classifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] button_level, [32:1] now_ms, [39:33] zero
    input  wire logic [bpc_pkg::InDataW-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [2:0] press_class, [18:3] repeat_count, [20:19] beep_code, [23:21] zero
    output logic [bpc_pkg::OutDataW-1:0]       m_axis_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bpc_pkg::IdxW-1:0]      cfg_index,
    input  wire logic [bpc_pkg::ThrW-1:0]      cfg_data
);
    import bpc_pkg::*;

    bpc_cfg_t    cfg;
    bpc_result_t result;

    logic             in_valid_reg;
    logic             in_level_reg;
    logic [TimeW-1:0] in_time_reg;
    logic             out_valid_reg;
    bpc_result_t      out_data_reg;
    logic             out_free;
    logic             step;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    bpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .button_level (in_level_reg),
        .now_ms       (in_time_reg),
        .cfg          (cfg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_level_reg <= s_axis_tdata[0];
            in_time_reg  <= s_axis_tdata[TimeW:1];
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OutDataW-ClassW-CountW-BeepW){1'b0}},
                            out_data_reg.beep_code,
                            out_data_reg.repeat_count,
                            out_data_reg.press_class};

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |-> !s_axis_tready)
        else $error("input accepted over a held beat");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_axis_tvalid)
        else $error("classified beat not presented");
`endif

endmodule
`default_nettype wire
